### sv/vssm_pkg.sv
// ----------------------------------------------------------------------------
// vssm_pkg: shared types and codes of the voice slot sample mixer
// Command and status codes, field widths and the accumulator control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package vssm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ADDR_W   = 16;
	localparam int LEN_W    = 17;
	localparam int SLOT_W   = 5;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 2;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUEUE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MIX   = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic clear;
		logic add;
	} acc_ctrl_t;

endpackage

`default_nettype wire

### sv/vssm_in_if.sv
// ----------------------------------------------------------------------------
// vssm_in_if: command channel of the voice slot sample mixer
// Valid/ready channel carrying one command with its address, sample and length.
// ----------------------------------------------------------------------------
`default_nettype none

interface vssm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [vssm_pkg::CMD_W-1:0]           command;
	logic [vssm_pkg::ADDR_W-1:0]          address;
	logic signed [vssm_pkg::SAMPLE_W-1:0] sample_value;
	logic [vssm_pkg::LEN_W-1:0]           sound_length;

	modport source (
		output valid, command, address, sample_value, sound_length,
		input  ready
	);
	modport sink (
		input  valid, command, address, sample_value, sound_length,
		output ready
	);
endinterface

`default_nettype wire

### sv/vssm_out_if.sv
// ----------------------------------------------------------------------------
// vssm_out_if: result channel of the voice slot sample mixer
// Valid/ready channel carrying the mixed sample, status and claimed slot.
// ----------------------------------------------------------------------------
`default_nettype none

interface vssm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vssm_pkg::SAMPLE_W-1:0] mixed_sample;
	logic [vssm_pkg::STAT_W-1:0]          status;
	logic [vssm_pkg::SLOT_W-1:0]          slot_index;

	modport source (
		output valid, mixed_sample, status, slot_index,
		input  ready
	);
	modport sink (
		input  valid, mixed_sample, status, slot_index,
		output ready
	);
endinterface

`default_nettype wire

### sv/vssm_mix_acc.sv
// ----------------------------------------------------------------------------
// vssm_mix_acc: saturating mix accumulator
// Shared adder: adds one voice sample per cycle while ctrl.add is set and clamps to signed 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_mix_acc (
	input  logic                                 clk,
	input  vssm_pkg::acc_ctrl_t                  ctrl,
	input  logic signed [vssm_pkg::SAMPLE_W-1:0] sample,
	output logic signed [vssm_pkg::SAMPLE_W-1:0] sum
);

	logic signed [vssm_pkg::SAMPLE_W-1:0] sum_q;
	logic signed [vssm_pkg::SAMPLE_W:0]   ext_sum;
	logic signed [vssm_pkg::SAMPLE_W-1:0] sat_sum;

	assign ext_sum = {sum_q[vssm_pkg::SAMPLE_W-1], sum_q}
		+ {sample[vssm_pkg::SAMPLE_W-1], sample};

	// Overflow shows as a mismatch of the two top bits; the sign picks the rail.
	always_comb begin
		if (ext_sum[vssm_pkg::SAMPLE_W] != ext_sum[vssm_pkg::SAMPLE_W-1]) begin
			sat_sum = ext_sum[vssm_pkg::SAMPLE_W]
				? {1'b1, {(vssm_pkg::SAMPLE_W-1){1'b0}}}
				: {1'b0, {(vssm_pkg::SAMPLE_W-1){1'b1}}};
		end else begin
			sat_sum = ext_sum[vssm_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.add) begin
			sum_q <= sat_sum;
		end
	end

	assign sum = sum_q;

endmodule

`default_nettype wire

### sv/voice_slot_sample_mixer.sv
// ----------------------------------------------------------------------------
// voice_slot_sample_mixer: multi-voice saturating PCM mixer
// Sample memory, a table of voice slots and one saturating adder under a
// small sequencer. Write, queue and mix commands each give one result.
// ----------------------------------------------------------------------------
// Sequence, from the transfer to the load of the result register: write, empty
//   sound and unused command go straight to the load; queue walks the slots
//   until the lowest free slot, or the whole table when full; mix walks every
//   slot, one slot per cycle through the memory read port, then a drain state
//   for the adder, then the load state.
// Flow: one command at a time; a mix walks the slots one at a time, set by
//   the single sample memory read port feeding the one shared adder, and
//   a stalled result register holds the sequencer until it empties.
// Reset: arst_n clears the sequencer, the voice active bits and the output
//   valid; sample memory and voice addresses/lengths hold until written.
`default_nettype none

module voice_slot_sample_mixer #(
	parameter int VOICE_SLOTS  = 32,
	parameter int SAMPLE_WORDS = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	vssm_in_if.sink    in_ch,
	vssm_out_if.source out_ch
);

	// Index widths derived from the table and memory sizes.
	localparam int IW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
	localparam int AW = $clog2(SAMPLE_WORDS);
	localparam logic [IW-1:0] LAST_SLOT = IW'(VOICE_SLOTS - 1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_QUEUE = 3'd1;
	localparam logic [2:0] ST_MIX   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]    state_q;
	logic [IW-1:0] idx_q;

	// Latched queue request.
	logic [vssm_pkg::ADDR_W-1:0] qaddr_q;
	logic [vssm_pkg::LEN_W-1:0]  qlen_q;

	// Result under construction.
	logic [vssm_pkg::STAT_W-1:0] res_status_q;
	logic [vssm_pkg::SLOT_W-1:0] res_slot_q;

	// Output register.
	logic                                 out_valid_q;
	logic signed [vssm_pkg::SAMPLE_W-1:0] out_mix_q;
	logic [vssm_pkg::STAT_W-1:0]          out_status_q;
	logic [vssm_pkg::SLOT_W-1:0]          out_slot_q;

	// Voice table: active bits reset, address and length hold until claimed.
	logic [VOICE_SLOTS-1:0]      voice_active_q;
	logic [vssm_pkg::ADDR_W-1:0] voice_addr_q [VOICE_SLOTS];
	logic [vssm_pkg::LEN_W-1:0]  voice_rem_q  [VOICE_SLOTS];

	// Sample memory with registered read.
	logic [vssm_pkg::SAMPLE_W-1:0] sample_mem [SAMPLE_WORDS];
	logic [vssm_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [AW-1:0]                 rd_addr;

	logic                                 in_xfer;
	logic                                 fin_load;
	logic                                 slot_free;
	logic                                 mix_hit;
	logic                                 add_s1;
	vssm_pkg::acc_ctrl_t                  acc_ctrl;
	logic signed [vssm_pkg::SAMPLE_W-1:0] acc_sum;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign fin_load    = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);
	assign slot_free   = !voice_active_q[idx_q];
	assign mix_hit     = (state_q == ST_MIX) && voice_active_q[idx_q];
	assign rd_addr     = AW'(voice_addr_q[idx_q]);

	// Sequencer: one slot per cycle for queue search and mix walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			res_status_q <= vssm_pkg::STATUS_OK;
			res_slot_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						idx_q        <= '0;
						res_status_q <= vssm_pkg::STATUS_OK;
						res_slot_q   <= '0;
						priority if (in_ch.command == vssm_pkg::CMD_QUEUE) begin
							if (in_ch.sound_length == '0) begin
								res_status_q <= vssm_pkg::STATUS_EMPTY;
								state_q      <= ST_FIN;
							end else begin
								state_q <= ST_QUEUE;
							end
						end else if (in_ch.command == vssm_pkg::CMD_MIX) begin
							state_q <= ST_MIX;
						end else begin
							// Write or unused command: result is all zero.
							state_q <= ST_FIN;
						end
					end
				end
				ST_QUEUE: begin
					if (slot_free) begin
						res_slot_q <= vssm_pkg::SLOT_W'(idx_q);
						state_q    <= ST_FIN;
					end else if (idx_q == LAST_SLOT) begin
						res_status_q <= vssm_pkg::STATUS_FULL;
						state_q      <= ST_FIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_MIX: begin
					if (idx_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					// Last sample lands in the accumulator this cycle.
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the queue request on transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			qaddr_q <= in_ch.address;
			qlen_q  <= in_ch.sound_length;
		end
	end

	// Claim a slot on queue; free a voice as its last sample is mixed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_active_q <= '0;
		end else if (state_q == ST_QUEUE && slot_free) begin
			voice_active_q[idx_q] <= 1'b1;
		end else if (mix_hit && voice_rem_q[idx_q] == vssm_pkg::LEN_W'(1)) begin
			voice_active_q[idx_q] <= 1'b0;
		end
	end

	// Load address and length on claim; advance read address and remaining count of each contributing voice.
	always_ff @(posedge clk) begin
		if (state_q == ST_QUEUE && slot_free) begin
			voice_addr_q[idx_q] <= qaddr_q;
			voice_rem_q[idx_q]  <= qlen_q;
		end else if (mix_hit) begin
			voice_addr_q[idx_q] <= voice_addr_q[idx_q] + vssm_pkg::ADDR_W'(1);
			voice_rem_q[idx_q]  <= voice_rem_q[idx_q] - vssm_pkg::LEN_W'(1);
		end
	end

	// Sample memory: write on a write command's transfer, read the walked voice every cycle.
	always_ff @(posedge clk) begin
		if (in_xfer && in_ch.command == vssm_pkg::CMD_WRITE) begin
			sample_mem[AW'(in_ch.address)] <= in_ch.sample_value;
		end
		rd_data_q <= sample_mem[rd_addr];
	end

	// Mark which read returns belong to an active voice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1 <= 1'b0;
		end else begin
			add_s1 <= mix_hit;
		end
	end

	// Clear the sum on every command so non-mix results read zero.
	assign acc_ctrl.clear = in_xfer;
	assign acc_ctrl.add   = add_s1;

	vssm_mix_acc u_acc (
		.clk    (clk),
		.ctrl   (acc_ctrl),
		.sample (rd_data_q),
		.sum    (acc_sum)
	);

	// Output register: hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_mix_q    <= acc_sum;
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.mixed_sample = out_mix_q;
	assign out_ch.status       = out_status_q;
	assign out_ch.slot_index   = out_slot_q;

endmodule

`default_nettype wire

### sv/vssm_checker.sv
// ----------------------------------------------------------------------------
// vssm_checker: port-level checks of the voice slot sample mixer
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic [vssm_pkg::CMD_W-1:0]           in_command,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [vssm_pkg::SAMPLE_W-1:0] out_mixed_sample,
	input logic [vssm_pkg::STAT_W-1:0]          out_status,
	input logic [vssm_pkg::SLOT_W-1:0]          out_slot_index
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mixed_sample)
			&& $stable(out_status) && $stable(out_slot_index))
		else $error("result changed while stalled");

	// One command at a time: ready drops after each transfer.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while busy");

	// A write into an empty output goes through the finish state straight to a valid result.
	a_write_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_command == vssm_pkg::CMD_WRITE && !out_valid
			|-> ##2 out_valid)
		else $error("write result late");

	// A failed or ignored queue carries no sample and no slot.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != vssm_pkg::STATUS_OK
			|-> out_mixed_sample == '0 && out_slot_index == '0)
		else $error("nonzero fields on failed queue");

endmodule

bind voice_slot_sample_mixer vssm_checker u_vssm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_command       (in_ch.command),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_mixed_sample (out_ch.mixed_sample),
	.out_status       (out_ch.status),
	.out_slot_index   (out_ch.slot_index)
);

`default_nettype wire
